[sv/blk2s_pkg.sv]
`timescale 1ns / 1ps

package blk2s_pkg;

    typedef logic [31:0] t_word;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DLEN = 3'd0,
        CFG_KLEN = 3'd1,
        CFG_KEY0 = 3'd2,
        CFG_KEY1 = 3'd3,
        CFG_KEY2 = 3'd4,
        CFG_KEY3 = 3'd5
    } t_cfg_idx;

    localparam t_word IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam t_word FINAL_MASK = 32'hFFFFFFFF;
    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS = 10;
    localparam logic [5:0] DLEN_MAX = 6'd32;
    localparam logic [5:0] KLEN_MAX = 6'd32;

    // Commands from the block sequencer to the compression engine.
    typedef struct packed {
        logic        init;
        logic [5:0]  dlen;
        logic [5:0]  klen;
        logic        start;
        logic        last;
        logic [63:0] counter;
        logic        we;
        logic [5:0]  waddr;
        logic [7:0]  wdata;
    } t_core_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    // The four words one mixing step works on.
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    // Message word schedule; entry k of a row sits in bits 4k+3:4k.
    function automatic logic [3:0] sigma_idx(input logic [3:0] round, input logic [3:0] pos);
        logic [63:0] row;
        unique case (round)
            4'd0: row = 64'hFEDCBA9876543210;
            4'd1: row = 64'h357B20C16DF984AE;
            4'd2: row = 64'h491763EADF250C8B;
            4'd3: row = 64'h8F04A562EBCD1397;
            4'd4: row = 64'hD386CB1EFA427509;
            4'd5: row = 64'h91EF57D438B0A6C2;
            4'd6: row = 64'hB8293670A4DEF15C;
            4'd7: row = 64'hA2684F05931CE7BD;
            4'd8: row = 64'h5A417D2C803B9EF6;
            4'd9: row = 64'h0DC3E9BF5167482A;
            default: row = 64'hFEDCBA9876543210;
        endcase
        return row[{pos, 2'b00} +: 4];
    endfunction

    // First chain word: IV xor the parameter word (fanout and depth of one).
    function automatic t_word param_word(input logic [5:0] dlen, input logic [5:0] klen);
        return IV[0] ^ {8'h01, 8'h01, 2'b00, klen, 2'b00, dlen};
    endfunction

endpackage

[sv/blk2s_if.sv]
`timescale 1ns / 1ps

// Message chunk channel.
interface blk2s_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] chunk;
    logic [3:0]  byte_count;
    logic        final_req;

    modport source (output valid, chunk, byte_count, final_req, input ready);
    modport sink   (input valid, chunk, byte_count, final_req, output ready);
endinterface

// Digest part channel.
interface blk2s_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic        part_last;

    modport source (output valid, digest_part, part_last, input ready);
    modport sink   (input valid, digest_part, part_last, output ready);
endinterface

// Configuration write channel.
interface blk2s_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/blk2s_mix.sv]
`timescale 1ns / 1ps

// One half of the G function: an add of three, a rotate, an add, a rotate.
module blk2s_mix (
    input  blk2s_pkg::t_quad i_q,
    input  blk2s_pkg::t_word i_m,
    input  logic             i_half,
    output blk2s_pkg::t_quad o_q
);

    blk2s_pkg::t_word a_sum;
    blk2s_pkg::t_word d_x;
    blk2s_pkg::t_word d_rot;
    blk2s_pkg::t_word c_sum;
    blk2s_pkg::t_word b_x;
    blk2s_pkg::t_word b_rot;

    always_comb begin
        a_sum = i_q.a + i_q.b + i_m;
        d_x   = i_q.d ^ a_sum;
        // The first half rotates by 16 and 12, the second by 8 and 7.
        d_rot = i_half ? {d_x[7:0], d_x[31:8]} : {d_x[15:0], d_x[31:16]};
        c_sum = i_q.c + d_rot;
        b_x   = i_q.b ^ c_sum;
        b_rot = i_half ? {b_x[6:0], b_x[31:7]} : {b_x[11:0], b_x[31:12]};
        o_q.a = a_sum;
        o_q.b = b_rot;
        o_q.c = c_sum;
        o_q.d = d_rot;
    end

endmodule

[sv/blk2s_compress.sv]
`timescale 1ns / 1ps

// Compression engine: holds the chain value and the block buffer, and runs
// ten rounds as 160 half-steps of one shared mixing unit.
module blk2s_compress (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  blk2s_pkg::t_core_cmd i_cmd,
    output blk2s_pkg::t_core_sts o_sts,
    output blk2s_pkg::t_word     o_chain [8]
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state           r_state;
    logic             r_done;
    blk2s_pkg::t_word r_v     [16];
    blk2s_pkg::t_word n_v     [16];
    blk2s_pkg::t_word w_v     [16];
    blk2s_pkg::t_word r_chain [8];
    blk2s_pkg::t_word r_mem   [16];
    blk2s_pkg::t_word r_mword;
    logic [3:0]       r_round;
    logic [3:0]       r_sub;
    logic [3:0]       nxt_round;
    logic [3:0]       nxt_sub;
    logic [3:0]       rd_addr;
    logic             diag;
    blk2s_pkg::t_quad mix_in;
    blk2s_pkg::t_quad mix_out;

    // Block buffer: byte writes from the loader, one word read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr[5:2]][{i_cmd.waddr[1:0], 3'b000} +: 8] <= i_cmd.wdata;
        end
        r_mword <= r_mem[rd_addr];
    end

    // The word for the next half-step is read from the buffer into a register during the current half-step.
    always_comb begin
        nxt_sub   = r_sub + 4'd1;
        nxt_round = (r_sub == 4'd15) ? r_round + 4'd1 : r_round;
        if (r_state == S_RUN) begin
            rd_addr = blk2s_pkg::sigma_idx(nxt_round, nxt_sub);
        end else begin
            rd_addr = blk2s_pkg::sigma_idx(4'd0, 4'd0);
        end
    end

    // The working state sits as four rows; the active column or diagonal is
    // always at the front, and the rows rotate after each full G.
    assign diag     = r_sub[3];
    assign mix_in.a = r_v[0];
    assign mix_in.b = diag ? r_v[5]  : r_v[4];
    assign mix_in.c = diag ? r_v[10] : r_v[8];
    assign mix_in.d = diag ? r_v[15] : r_v[12];

    blk2s_mix u_mix (
        .i_q    (mix_in),
        .i_m    (r_mword),
        .i_half (r_sub[0]),
        .o_q    (mix_out)
    );

    always_comb begin
        w_v = r_v;
        w_v[0] = mix_out.a;
        if (diag) begin
            w_v[5]  = mix_out.b;
            w_v[10] = mix_out.c;
            w_v[15] = mix_out.d;
        end else begin
            w_v[4]  = mix_out.b;
            w_v[8]  = mix_out.c;
            w_v[12] = mix_out.d;
        end
        n_v = w_v;
        if (r_sub[0]) begin
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 4; j++) begin
                    n_v[4 * r + j] = w_v[4 * r + ((j + 1) % 4)];
                end
            end
        end
    end

    // Sequencer, working state and chain value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_round <= '0;
            r_sub   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.init) begin
                        r_chain[0] <= blk2s_pkg::param_word(i_cmd.dlen, i_cmd.klen);
                        for (int i = 1; i < 8; i++) begin
                            r_chain[i] <= blk2s_pkg::IV[i];
                        end
                    end
                    if (i_cmd.start) begin
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_chain[i];
                        end
                        r_v[8]  <= blk2s_pkg::IV[0];
                        r_v[9]  <= blk2s_pkg::IV[1];
                        r_v[10] <= blk2s_pkg::IV[2];
                        r_v[11] <= blk2s_pkg::IV[3];
                        r_v[12] <= blk2s_pkg::IV[4] ^ i_cmd.counter[31:0];
                        r_v[13] <= blk2s_pkg::IV[5] ^ i_cmd.counter[63:32];
                        r_v[14] <= blk2s_pkg::IV[6]
                                   ^ (i_cmd.last ? blk2s_pkg::FINAL_MASK : '0);
                        r_v[15] <= blk2s_pkg::IV[7];
                        r_round <= '0;
                        r_sub   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_v     <= n_v;
                    r_sub   <= nxt_sub;
                    r_round <= nxt_round;
                    if (r_sub == 4'd15 && r_round == 4'(blk2s_pkg::ROUNDS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] ^ r_v[i] ^ r_v[i + 8];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = r_done;
    assign o_chain    = r_chain;

    // A finished compression is reported only from the closing step.
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == S_FIN)
        else $error("done without a closing step");

    // The schedule never passes the last round.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_round < 4'(blk2s_pkg::ROUNDS)))
        else $error("round counter out of range");

    // A start is only taken when the engine is free.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && r_state == S_IDLE) |=> (r_state == S_RUN))
        else $error("start not taken");

endmodule

[sv/blake2s_hash_unit.sv]
`timescale 1ns / 1ps
// Sequence: a chunk is accepted, its bytes are written to the buffer one per cycle, then a
// closing step ends it before the next chunk is taken; a keyed message starts with a key block.
// Each block compression has a start step, 160 half-steps of one shared G unit, a feed-forward
// step and a step to see done; loading waits for it at a block boundary. The final chunk adds
// padding bytes one per cycle and a compression, then a digest beat per cycle on o_dig.ready.
// Reset (synchronous, active low) restores the default configuration and clears control state.
module blake2s_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blk2s_in_if.sink    i_msg,
    blk2s_out_if.source o_dig,
    blk2s_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE, S_KEY, S_BYTES, S_WAIT_MID, S_PAD, S_WAIT_FIN, S_OUT
    } t_state;

    t_state               r_state;
    logic                 r_fresh;
    logic [6:0]           r_fill;
    logic [63:0]          r_counter;
    logic [63:0]          r_chunk;
    logic [3:0]           r_left;
    logic                 r_fin;
    logic [5:0]           r_mdlen;
    logic [5:0]           r_klen_m;
    logic [5:0]           r_rem;
    logic [63:0]          r_dig [4];
    logic [5:0]           r_dlen;
    logic [5:0]           r_klen;
    logic [63:0]          r_key [4];
    logic [5:0]           eff_dlen;
    logic [5:0]           eff_klen;
    logic [3:0]           in_cnt;
    logic [255:0]         key_flat;
    logic [7:0]           key_byte;
    blk2s_pkg::t_core_cmd cmd;
    blk2s_pkg::t_core_sts sts;
    blk2s_pkg::t_word     chain [8];

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen <= blk2s_pkg::DLEN_MAX;
            r_klen <= '0;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                blk2s_pkg::CFG_DLEN: r_dlen   <= i_cfg.data[5:0];
                blk2s_pkg::CFG_KLEN: r_klen   <= i_cfg.data[5:0];
                blk2s_pkg::CFG_KEY0: r_key[0] <= i_cfg.data;
                blk2s_pkg::CFG_KEY1: r_key[1] <= i_cfg.data;
                blk2s_pkg::CFG_KEY2: r_key[2] <= i_cfg.data;
                blk2s_pkg::CFG_KEY3: r_key[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Clamped lengths and the key byte for the key block.
    always_comb begin
        if (r_dlen == '0) begin
            eff_dlen = 6'd1;
        end else if (r_dlen > blk2s_pkg::DLEN_MAX) begin
            eff_dlen = blk2s_pkg::DLEN_MAX;
        end else begin
            eff_dlen = r_dlen;
        end
        eff_klen = (r_klen > blk2s_pkg::KLEN_MAX) ? blk2s_pkg::KLEN_MAX : r_klen;
        in_cnt   = (i_msg.byte_count > 4'd8) ? 4'd8 : i_msg.byte_count;
        key_flat = {r_key[3], r_key[2], r_key[1], r_key[0]};
        key_byte = (r_fill < {1'b0, r_klen_m}) ? key_flat[{r_fill[4:0], 3'b000} +: 8] : 8'h00;
    end

    // Commands to the compression engine.
    always_comb begin
        cmd = '0;
        cmd.dlen  = eff_dlen;
        cmd.klen  = eff_klen;
        cmd.waddr = r_fill[5:0];
        unique case (r_state)
            S_IDLE: begin
                cmd.init = i_msg.valid && r_fresh && (i_msg.final_req || in_cnt != '0);
            end
            S_KEY: begin
                cmd.we    = 1'b1;
                cmd.wdata = key_byte;
            end
            S_BYTES: begin
                if (r_left != '0) begin
                    if (r_fill == 7'(blk2s_pkg::BLOCK_BYTES)) begin
                        cmd.start   = 1'b1;
                        cmd.counter = r_counter + 64'(blk2s_pkg::BLOCK_BYTES);
                    end else begin
                        cmd.we    = 1'b1;
                        cmd.wdata = r_chunk[7:0];
                    end
                end
            end
            S_PAD: begin
                if (r_fill == 7'(blk2s_pkg::BLOCK_BYTES)) begin
                    cmd.start   = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.counter = r_counter;
                end else begin
                    cmd.we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    blk2s_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_chain (chain)
    );

    // Message sequencer: key block, byte loading, padding and digest output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fresh <= 1'b1;
            r_fill  <= '0;
            r_left  <= '0;
            r_rem   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_msg.valid && (i_msg.final_req || in_cnt != '0)) begin
                        r_chunk <= i_msg.chunk;
                        r_left  <= in_cnt;
                        r_fin   <= i_msg.final_req;
                        r_state <= S_BYTES;
                        if (r_fresh) begin
                            r_fresh   <= 1'b0;
                            r_mdlen   <= eff_dlen;
                            r_klen_m  <= eff_klen;
                            r_counter <= '0;
                            r_fill    <= '0;
                            if (eff_klen != '0) begin
                                r_state <= S_KEY;
                            end
                        end
                    end
                end
                S_KEY: begin
                    r_fill <= r_fill + 7'd1;
                    if (r_fill == 7'(blk2s_pkg::BLOCK_BYTES - 1)) begin
                        r_state <= S_BYTES;
                    end
                end
                S_BYTES: begin
                    if (r_left == '0) begin
                        if (r_fin) begin
                            r_counter <= r_counter + 64'(r_fill);
                            r_state   <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_fill == 7'(blk2s_pkg::BLOCK_BYTES)) begin
                        r_counter <= cmd.counter;
                        r_fill    <= '0;
                        r_state   <= S_WAIT_MID;
                    end else begin
                        r_chunk <= {8'h00, r_chunk[63:8]};
                        r_left  <= r_left - 4'd1;
                        r_fill  <= r_fill + 7'd1;
                    end
                end
                S_WAIT_MID: begin
                    if (sts.done) begin
                        r_state <= S_BYTES;
                    end
                end
                S_PAD: begin
                    if (r_fill == 7'(blk2s_pkg::BLOCK_BYTES)) begin
                        r_state <= S_WAIT_FIN;
                    end else begin
                        r_fill <= r_fill + 7'd1;
                    end
                end
                S_WAIT_FIN: begin
                    if (sts.done) begin
                        for (int i = 0; i < 4; i++) begin
                            r_dig[i] <= {chain[2 * i + 1], chain[2 * i]};
                        end
                        r_rem   <= r_mdlen;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_dig.ready) begin
                        for (int i = 0; i < 3; i++) begin
                            r_dig[i] <= r_dig[i + 1];
                        end
                        if (r_rem <= 6'd8) begin
                            r_rem   <= '0;
                            r_fresh <= 1'b1;
                            r_fill  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_rem <= r_rem - 6'd8;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Digest beats: bytes beyond the digest length are cleared.
    assign i_msg.ready     = (r_state == S_IDLE);
    assign o_dig.valid     = (r_state == S_OUT);
    assign o_dig.part_last = (r_rem <= 6'd8);

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            o_dig.digest_part[8 * k +: 8] = (6'(k) < r_rem) ? r_dig[0][8 * k +: 8] : 8'h00;
        end
    end

    // No chunk is taken while a digest is being delivered.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig.valid |-> !i_msg.ready)
        else $error("input open during digest output");

    // The engine only finishes while the sequencer waits for it.
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.done |-> (r_state == S_WAIT_MID || r_state == S_WAIT_FIN))
        else $error("unexpected compression done");

    // The buffer never holds more than one block.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 7'(blk2s_pkg::BLOCK_BYTES))
        else $error("fill count above one block");

    // A digest beat always carries at least one byte.
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig.valid |-> (r_rem != '0))
        else $error("digest beat with no bytes");

    // A start always finds the engine free and makes it busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> (!sts.busy ##1 sts.busy))
        else $error("compression start lost");

endmodule
